// File: rtl/pep_pkg.sv
// Shared types and constants for the pointer event processor.
`default_nettype none
package pep_pkg;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [3:0] {
        KIND_MOVE = 4'd0,
        KIND_PRESS = 4'd1,
        KIND_RELEASE = 4'd2,
        KIND_VSCROLL = 4'd3,
        KIND_HSCROLL = 4'd4,
        KIND_WARP = 4'd5,
        KIND_CLICK = 4'd14,
        KIND_DCLICK = 4'd15
    } kind_code_t;

    typedef enum logic [2:0] {
        REG_WIDTH = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_INVERT = 3'd2,
        REG_GAIN = 3'd3,
        REG_KNEE = 3'd4,
        REG_DEBOUNCE = 3'd5,
        REG_HOLD = 3'd6,
        REG_GAP = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ACC_X,
        ST_DIV_X,
        ST_FIN_X,
        ST_ACC_Y,
        ST_DIV_Y,
        ST_FIN_Y,
        ST_OUT1,
        ST_OUT2
    } state_t;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [15:0] ptr_x;
        logic [15:0] ptr_y;
        logic signed [15:0] step_x;
        logic signed [15:0] step_y;
        logic signed [15:0] wheel_v;
        logic signed [15:0] wheel_h;
        logic [7:0] button_out;
        logic [7:0] click_number;
        logic last_of_run;
    } result_t;

    typedef struct packed {
        logic start;
        logic [39:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [39:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/pep_if.sv
// Valid/ready stream interface carrying input items and result items.
`default_nettype none
interface pep_in_if;
    logic valid;
    logic ready;
    logic [3:0] kind;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [15:0] scroll_v;
    logic signed [15:0] scroll_h;
    logic [7:0] button_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0] clicks_in;
    logic [31:0] time_ms;
    modport source (output valid, kind, move_x, move_y, scroll_v, scroll_h, button_index,
                    pos_x, pos_y, clicks_in, time_ms, input ready);
    modport sink (input valid, kind, move_x, move_y, scroll_v, scroll_h, button_index,
                  pos_x, pos_y, clicks_in, time_ms, output ready);
endinterface

interface pep_out_if;
    logic valid;
    logic ready;
    logic [3:0] event_kind;
    logic [15:0] ptr_x;
    logic [15:0] ptr_y;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic signed [15:0] wheel_v;
    logic signed [15:0] wheel_h;
    logic [7:0] button_out;
    logic [7:0] click_number;
    logic last_of_run;
    modport source (output valid, event_kind, ptr_x, ptr_y, step_x, step_y, wheel_v,
                    wheel_h, button_out, click_number, last_of_run, input ready);
    modport sink (input valid, event_kind, ptr_x, ptr_y, step_x, step_y, wheel_v,
                  wheel_h, button_out, click_number, last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/pep_divider.sv
// Restoring divider, one quotient bit per cycle, 40-bit by 16-bit.
`default_nettype none
module pep_divider (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pep_pkg::div_req_t req,
    output pep_pkg::div_rsp_t rsp
);
    import pep_pkg::*;

    localparam int NW = 40;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[15:0], quo_reg[NW-1]};
        diff = {1'b0, trial} - {2'b00, dvs_reg};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == CW'(1)) |=> done_reg)
        else $error("divider missed done");
    assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_reg)
        else $error("divider did not start");
endmodule
`default_nettype wire

// File: rtl/pointer_event_processor.sv
// Top level: pointer acceleration, cursor tracking and click detection.
// Results: a move result goes out after two divides on the shared divider, X then Y;
// other kinds after dispatch; an ignored press or release gives none; a release click
// adds one result. Input reopens only in idle, once all results of the event are taken.
// Reset: cursor to center of reset screen, remainders and button state cleared,
// registers to their defaults.
`default_nettype none
module pointer_event_processor #(
    parameter int BUTTON_COUNT = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pep_in_if.sink in_ch,
    pep_out_if.source out_ch,
    input  wire logic cfg_we,
    input  wire logic [pep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pep_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pep_pkg::*;

    localparam int BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    logic [15:0] width_reg, height_reg, gain_reg, knee_reg, deb_reg, hold_reg, gap_reg;
    logic [1:0] inv_reg;

    state_t state_reg, state_next;

    logic [3:0] kind_reg;
    logic signed [15:0] mx_reg, my_reg, sv_reg, sh_reg;
    logic [7:0] btn_reg, clk_in_reg;
    logic [15:0] px_reg, py_reg;
    logic [31:0] now_reg;

    logic [15:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [8:0] rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [BUTTON_COUNT-1:0] down_reg, down_next, conf_reg, conf_next, pend_reg, pend_next;
    logic [31:0] press_t_reg [BUTTON_COUNT];
    logic [31:0] change_t_reg [BUTTON_COUNT];
    logic [31:0] click_t_reg [BUTTON_COUNT];

    result_t r1_reg, r1_next, r2_reg, r2_next;
    logic [15:0] step_x_reg, step_x_next;
    logic [15:0] mag_reg, mag_next;
    logic neg_reg, neg_next;
    logic signed [59:0] sum_reg, sum_next;
    logic [16:0] knee_eff;

    div_req_t dreq;
    div_rsp_t drsp;

    pep_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 16'd1920;
            height_reg <= 16'd1080;
            inv_reg <= 2'd0;
            gain_reg <= 16'd256;
            knee_reg <= 16'd1024;
            deb_reg <= 16'd20;
            hold_reg <= 16'd300;
            gap_reg <= 16'd400;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_WIDTH: width_reg <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_INVERT: inv_reg <= cfg_data[1:0];
                REG_GAIN: gain_reg <= cfg_data;
                REG_KNEE: knee_reg <= cfg_data;
                REG_DEBOUNCE: deb_reg <= cfg_data;
                REG_HOLD: hold_reg <= cfg_data;
                REG_GAP: gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign knee_eff = (knee_reg == 16'd0) ? 17'd1 : {1'b0, knee_reg};

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= in_ch.kind;
            mx_reg <= in_ch.move_x;
            my_reg <= in_ch.move_y;
            sv_reg <= in_ch.scroll_v;
            sh_reg <= in_ch.scroll_h;
            btn_reg <= in_ch.button_index;
            px_reg <= in_ch.pos_x;
            py_reg <= in_ch.pos_y;
            clk_in_reg <= in_ch.clicks_in;
            now_reg <= in_ch.time_ms;
        end
    end

    // Axis math helpers, shared by both axes through the current-axis selection.
    logic axis_y;
    logic signed [15:0] d_raw;
    logic signed [16:0] d_axis;
    logic [16:0] mag_axis;
    logic [24:0] s_axis;
    logic over_knee;
    logic [24:0] excess;
    logic [40:0] prod;
    logic [40:0] scale;
    logic [57:0] amag;
    logic signed [59:0] accel_v;
    logic signed [59:0] sum_v;
    logic signed [59:0] ipart;
    logic signed [8:0] rem_cur;
    logic [15:0] cur_cur, bound;
    logic signed [60:0] pos_sum;
    logic [15:0] clamped;
    logic [15:0] sat_step;
    logic [15:0] size_cur;
    logic mag_top_reg;

    assign axis_y = (state_reg == ST_ACC_Y) || (state_reg == ST_DIV_Y)
                    || (state_reg == ST_FIN_Y);
    assign d_raw = axis_y ? my_reg : mx_reg;
    assign d_axis = (axis_y && inv_reg[0]) ? -17'(d_raw) : 17'(d_raw);
    assign mag_axis = d_axis[16] ? 17'(-d_axis) : 17'(d_axis);
    assign s_axis = {mag_axis[16:0], 8'd0};
    assign over_knee = s_axis > 25'(knee_eff);
    assign excess = s_axis - 25'(knee_eff);
    assign prod = 41'(excess) * 41'(gain_reg);
    assign scale = 41'd256 + drsp.quotient;
    assign amag = over_knee ? 58'({mag_top_reg, mag_reg}) * 58'(scale[40:0])
                            : {34'd0, mag_reg, 8'd0};
    assign accel_v = neg_reg ? -60'(amag) : 60'(amag);
    assign rem_cur = axis_y ? rem_y_reg : rem_x_reg;
    assign sum_v = accel_v + 60'(rem_cur);
    assign ipart = (sum_reg < 0) ? -((-sum_reg) >>> 8) : (sum_reg >>> 8);
    assign cur_cur = axis_y ? cur_y_reg : cur_x_reg;
    assign size_cur = axis_y ? height_reg : width_reg;
    assign bound = (size_cur == 16'd0) ? 16'd0 : size_cur - 16'd1;
    assign pos_sum = 61'(ipart) + 61'({1'b0, cur_cur});
    assign clamped = (pos_sum < 0) ? 16'd0 :
                     (pos_sum > 61'(bound)) ? bound : pos_sum[15:0];
    assign sat_step = (ipart < -60'sd32768) ? 16'h8000 :
                      (ipart > 60'sd32767) ? 16'h7fff : ipart[15:0];

    logic [BW-1:0] bi;
    logic btn_ok;
    logic debounced;
    logic click_ok;
    logic dbl;
    assign bi = btn_reg[BW-1:0];
    assign btn_ok = {24'd0, btn_reg} < 32'(BUTTON_COUNT);
    assign debounced = conf_reg[bi] && ((now_reg - change_t_reg[bi]) < {16'd0, deb_reg});
    assign click_ok = (now_reg - press_t_reg[bi]) <= {16'd0, hold_reg};
    assign dbl = pend_reg[bi] && ((now_reg - click_t_reg[bi]) <= {16'd0, gap_reg});

    result_t echo;
    always_comb
    begin
        echo.event_kind = kind_reg;
        echo.ptr_x = px_reg;
        echo.ptr_y = py_reg;
        echo.step_x = mx_reg;
        echo.step_y = my_reg;
        echo.wheel_v = sv_reg;
        echo.wheel_h = sh_reg;
        echo.button_out = btn_reg;
        echo.click_number = clk_in_reg;
        echo.last_of_run = 1'b1;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (kind_reg)
                    KIND_MOVE: state_next = ST_ACC_X;
                    KIND_PRESS: state_next = (btn_ok && !debounced) ? ST_OUT1 : ST_IDLE;
                    KIND_RELEASE: state_next = (btn_ok && down_reg[bi]) ? ST_OUT1 : ST_IDLE;
                    default: state_next = ST_OUT1;
                endcase
            end
            ST_ACC_X: state_next = ST_DIV_X;
            ST_DIV_X: if (drsp.done) state_next = ST_FIN_X;
            ST_FIN_X: state_next = ST_ACC_Y;
            ST_ACC_Y: state_next = ST_DIV_Y;
            ST_DIV_Y: if (drsp.done) state_next = ST_FIN_Y;
            ST_FIN_Y: state_next = ST_OUT1;
            ST_OUT1: if (out_ch.ready) state_next = r1_reg.last_of_run ? ST_IDLE : ST_OUT2;
            ST_OUT2: if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        down_next = down_reg;
        conf_next = conf_reg;
        pend_next = pend_reg;
        r1_next = r1_reg;
        r2_next = r2_reg;
        step_x_next = step_x_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        sum_next = sum_reg;
        dreq.start = 1'b0;
        dreq.dividend = 40'(prod);
        dreq.divisor = knee_eff[15:0];
        case (state_reg)
            ST_DISPATCH:
            begin
                r1_next = echo;
                r2_next = echo;
                case (kind_reg)
                    KIND_PRESS:
                    begin
                        r1_next.ptr_x = cur_x_reg;
                        r1_next.ptr_y = cur_y_reg;
                        if (btn_ok && !debounced)
                        begin
                            down_next[bi] = 1'b1;
                            conf_next[bi] = 1'b1;
                        end
                    end
                    KIND_RELEASE:
                    begin
                        r1_next.ptr_x = cur_x_reg;
                        r1_next.ptr_y = cur_y_reg;
                        r2_next.ptr_x = cur_x_reg;
                        r2_next.ptr_y = cur_y_reg;
                        if (btn_ok && down_reg[bi])
                        begin
                            down_next[bi] = 1'b0;
                            if (click_ok)
                            begin
                                r1_next.last_of_run = 1'b0;
                                r2_next.event_kind = dbl ? KIND_DCLICK : KIND_CLICK;
                                r2_next.click_number = dbl ? 8'd2 : 8'd1;
                                pend_next[bi] = !dbl;
                            end
                        end
                    end
                    KIND_VSCROLL: if (inv_reg[1]) r1_next.wheel_v = -sv_reg;
                    KIND_HSCROLL: if (inv_reg[1]) r1_next.wheel_h = -sh_reg;
                    KIND_WARP:
                    begin
                        cur_x_next = (px_reg > ((width_reg == 16'd0) ? 16'd0 : width_reg - 16'd1))
                            ? ((width_reg == 16'd0) ? 16'd0 : width_reg - 16'd1) : px_reg;
                        cur_y_next = (py_reg > ((height_reg == 16'd0) ? 16'd0 : height_reg - 16'd1))
                            ? ((height_reg == 16'd0) ? 16'd0 : height_reg - 16'd1) : py_reg;
                        rem_x_next = '0;
                        rem_y_next = '0;
                    end
                    default: ;
                endcase
            end
            ST_ACC_X, ST_ACC_Y:
            begin
                mag_next = mag_axis[15:0];
                neg_next = d_axis[16];
                dreq.start = 1'b1;
            end
            ST_DIV_X, ST_DIV_Y:
            begin
                if (drsp.done)
                    sum_next = sum_v;
            end
            ST_FIN_X:
            begin
                rem_x_next = 9'(sum_reg - (ipart <<< 8));
                cur_x_next = clamped;
                step_x_next = sat_step;
            end
            ST_FIN_Y:
            begin
                rem_y_next = 9'(sum_reg - (ipart <<< 8));
                cur_y_next = clamped;
                r1_next.ptr_x = cur_x_reg;
                r1_next.ptr_y = clamped;
                r1_next.step_x = step_x_reg;
                r1_next.step_y = sat_step;
            end
            default: ;
        endcase
    end

    // The magnitude of -32768 is 32768 and fits in 16 bits; the top bit is kept for the multiply.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC_X || state_reg == ST_ACC_Y)
            mag_top_reg <= mag_axis[16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_x_reg <= 16'd960;
            cur_y_reg <= 16'd540;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            down_reg <= '0;
            conf_reg <= '0;
            pend_reg <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                press_t_reg[i] <= '0;
                change_t_reg[i] <= '0;
                click_t_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            down_reg <= down_next;
            conf_reg <= conf_next;
            pend_reg <= pend_next;
            if (state_reg == ST_DISPATCH && btn_ok)
            begin
                if (kind_reg == KIND_PRESS && !debounced)
                begin
                    press_t_reg[bi] <= now_reg;
                    change_t_reg[bi] <= now_reg;
                end
                if (kind_reg == KIND_RELEASE && down_reg[bi])
                begin
                    change_t_reg[bi] <= now_reg;
                    if (click_ok)
                        click_t_reg[bi] <= now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg <= r1_next;
        r2_reg <= r2_next;
        step_x_reg <= step_x_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        sum_reg <= sum_next;
    end

    assign in_ch.ready = (state_reg == ST_IDLE);

    result_t shown;
    assign shown = (state_reg == ST_OUT2) ? r2_reg : r1_reg;
    assign out_ch.valid = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);
    assign out_ch.event_kind = shown.event_kind;
    assign out_ch.ptr_x = shown.ptr_x;
    assign out_ch.ptr_y = shown.ptr_y;
    assign out_ch.step_x = shown.step_x;
    assign out_ch.step_y = shown.step_y;
    assign out_ch.wheel_v = shown.wheel_v;
    assign out_ch.wheel_h = shown.wheel_h;
    assign out_ch.button_out = shown.button_out;
    assign out_ch.click_number = shown.click_number;
    assign out_ch.last_of_run = shown.last_of_run;

    assert property (@(posedge clk) disable iff (!rst_n) out_ch.valid |-> !in_ch.ready)
        else $error("input open while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT2) |-> out_ch.last_of_run)
        else $error("second result not last");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_X || state_reg == ST_DIV_Y) |-> (drsp.busy || drsp.done))
        else $error("divider idle during divide");
endmodule
`default_nettype wire

// File: verif/tb_pointer_event_processor.sv
// Self-checking testbench for pointer_event_processor: random and directed mouse events.
module tb_pointer_event_processor;
    import pep_pkg::*;

    localparam int NUM_BUTTONS = 8;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SEG_ITEMS = 255;

    typedef struct {
        logic [3:0] kind;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [15:0] scroll_v;
        logic signed [15:0] scroll_h;
        logic [7:0] button_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0] clicks_in;
        logic [31:0] time_ms;
    } mouse_event_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pep_in_if in_ch();
    pep_out_if out_ch();

    pointer_event_processor #(.BUTTON_COUNT(NUM_BUTTONS)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    mouse_event_t pending_events[$];
    result_t expected_results[$];

    logic [15:0] m_width, m_height, m_gain, m_knee, m_debounce, m_hold, m_gap;
    logic [1:0] m_invert;
    logic [15:0] m_cur_x, m_cur_y;
    longint m_rem_x, m_rem_y;
    logic btn_down[NUM_BUTTONS];
    logic btn_confirmed[NUM_BUTTONS];
    logic btn_pending[NUM_BUTTONS];
    logic [31:0] btn_press_ms[NUM_BUTTONS];
    logic [31:0] btn_change_ms[NUM_BUTTONS];
    logic [31:0] btn_click_ms[NUM_BUTTONS];

    int send_idle_pct;
    int recv_idle_pct;
    logic hold_request;
    int hold_left;
    logic in_fire;
    int errors;
    int idle_cycles;
    int events_sent;
    int results_seen;
    int clicks_seen;
    int dclicks_seen;
    logic [31:0] now_ms;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint accel_q8(int d);
        longint mag;
        longint s;
        longint t;
        longint scale;
        longint r;
        mag = (d < 0) ? -longint'(d) : longint'(d);
        s = mag * 256;
        t = (m_knee == 16'd0) ? 64'd1 : longint'(m_knee);
        if (s <= t)
            return longint'(d) * 256;
        scale = 256 + ((s - t) * longint'(m_gain)) / t;
        r = mag * scale;
        return (d < 0) ? -r : r;
    endfunction

    function automatic logic [15:0] clamp_to_screen(longint v, logic [15:0] size);
        longint hi;
        hi = (size == 16'd0) ? 0 : longint'(size) - 1;
        if (v < 0)
            return 16'd0;
        if (v > hi)
            return hi[15:0];
        return v[15:0];
    endfunction

    function automatic logic [15:0] sat_step(longint v);
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v[15:0];
    endfunction

    function automatic void reset_pointer_state();
        m_width = 16'd1920; m_height = 16'd1080; m_invert = 2'd0;
        m_gain = 16'd256; m_knee = 16'd1024; m_debounce = 16'd20;
        m_hold = 16'd300; m_gap = 16'd400;
        m_cur_x = 16'd960; m_cur_y = 16'd540;
        m_rem_x = 0; m_rem_y = 0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            btn_down[i] = 1'b0; btn_confirmed[i] = 1'b0; btn_pending[i] = 1'b0;
            btn_press_ms[i] = '0; btn_change_ms[i] = '0; btn_click_ms[i] = '0;
        end
    endfunction

    function automatic void apply_reg(reg_index_t idx, logic [15:0] v);
        case (idx)
            REG_WIDTH: m_width = v;
            REG_HEIGHT: m_height = v;
            REG_INVERT: m_invert = v[1:0];
            REG_GAIN: m_gain = v;
            REG_KNEE: m_knee = v;
            REG_DEBOUNCE: m_debounce = v;
            REG_HOLD: m_hold = v;
            REG_GAP: m_gap = v;
            default: ;
        endcase
    endfunction

    function automatic void predict_pointer_results(mouse_event_t ev);
        result_t r;
        result_t c;
        int b;
        int dx;
        int dy;
        longint ax;
        longint ay;
        longint ix;
        longint iy;
        r.event_kind = ev.kind;
        r.ptr_x = ev.pos_x;
        r.ptr_y = ev.pos_y;
        r.step_x = ev.move_x;
        r.step_y = ev.move_y;
        r.wheel_v = ev.scroll_v;
        r.wheel_h = ev.scroll_h;
        r.button_out = ev.button_index;
        r.click_number = ev.clicks_in;
        r.last_of_run = 1'b1;
        b = ev.button_index;
        case (ev.kind)
            KIND_MOVE:
            begin
                dx = ev.move_x;
                dy = ev.move_y;
                if (m_invert[0])
                    dy = -dy;
                ax = m_rem_x + accel_q8(dx);
                ay = m_rem_y + accel_q8(dy);
                ix = ax / 256;
                iy = ay / 256;
                m_rem_x = ax - ix * 256;
                m_rem_y = ay - iy * 256;
                m_cur_x = clamp_to_screen(longint'(m_cur_x) + ix, m_width);
                m_cur_y = clamp_to_screen(longint'(m_cur_y) + iy, m_height);
                r.ptr_x = m_cur_x;
                r.ptr_y = m_cur_y;
                r.step_x = sat_step(ix);
                r.step_y = sat_step(iy);
                expected_results.push_back(r);
            end
            KIND_PRESS:
            begin
                if (b >= NUM_BUTTONS)
                    return;
                if (btn_confirmed[b] && (ev.time_ms - btn_change_ms[b]) < {16'd0, m_debounce})
                    return;
                btn_down[b] = 1'b1;
                btn_confirmed[b] = 1'b1;
                btn_press_ms[b] = ev.time_ms;
                btn_change_ms[b] = ev.time_ms;
                r.ptr_x = m_cur_x;
                r.ptr_y = m_cur_y;
                expected_results.push_back(r);
            end
            KIND_RELEASE:
            begin
                if (b >= NUM_BUTTONS || !btn_down[b])
                    return;
                btn_down[b] = 1'b0;
                btn_change_ms[b] = ev.time_ms;
                r.ptr_x = m_cur_x;
                r.ptr_y = m_cur_y;
                if ((ev.time_ms - btn_press_ms[b]) > {16'd0, m_hold})
                begin
                    expected_results.push_back(r);
                    return;
                end
                r.last_of_run = 1'b0;
                expected_results.push_back(r);
                c = r;
                c.last_of_run = 1'b1;
                if (btn_pending[b] && (ev.time_ms - btn_click_ms[b]) <= {16'd0, m_gap})
                begin
                    c.event_kind = KIND_DCLICK;
                    c.click_number = 8'd2;
                    btn_pending[b] = 1'b0;
                end
                else
                begin
                    c.event_kind = KIND_CLICK;
                    c.click_number = 8'd1;
                    btn_pending[b] = 1'b1;
                end
                btn_click_ms[b] = ev.time_ms;
                expected_results.push_back(c);
            end
            KIND_VSCROLL:
            begin
                if (m_invert[1])
                    r.wheel_v = -ev.scroll_v;
                expected_results.push_back(r);
            end
            KIND_HSCROLL:
            begin
                if (m_invert[1])
                    r.wheel_h = -ev.scroll_h;
                expected_results.push_back(r);
            end
            KIND_WARP:
            begin
                m_cur_x = clamp_to_screen(longint'(ev.pos_x), m_width);
                m_cur_y = clamp_to_screen(longint'(ev.pos_y), m_height);
                m_rem_x = 0;
                m_rem_y = 0;
                expected_results.push_back(r);
            end
            default: expected_results.push_back(r);
        endcase
    endfunction

    // transfer side: predict on acceptance, check results in order
    always @(posedge clk)
    begin
        result_t act;
        result_t exp_r;
        in_fire <= in_ch.valid && in_ch.ready;
        if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_pointer_results('{in_ch.kind, in_ch.move_x, in_ch.move_y, in_ch.scroll_v,
                                      in_ch.scroll_h, in_ch.button_index, in_ch.pos_x,
                                      in_ch.pos_y, in_ch.clicks_in, in_ch.time_ms});
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            act.event_kind = out_ch.event_kind;
            act.ptr_x = out_ch.ptr_x;
            act.ptr_y = out_ch.ptr_y;
            act.step_x = out_ch.step_x;
            act.step_y = out_ch.step_y;
            act.wheel_v = out_ch.wheel_v;
            act.wheel_h = out_ch.wheel_h;
            act.button_out = out_ch.button_out;
            act.click_number = out_ch.click_number;
            act.last_of_run = out_ch.last_of_run;
            if (act.event_kind == KIND_CLICK)
                clicks_seen <= clicks_seen + 1;
            if (act.event_kind == KIND_DCLICK)
                dclicks_seen <= dclicks_seen + 1;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result kind=%0d x=%0d y=%0d",
                             act.event_kind, act.ptr_x, act.ptr_y);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR: result mismatch at %0t", $realtime);
                        $write("  exp kind=%0d xy=%0d,%0d step=%0d,%0d",
                               exp_r.event_kind, exp_r.ptr_x, exp_r.ptr_y,
                               exp_r.step_x, exp_r.step_y);
                        $display(" wheel=%0d,%0d btn=%0d clk=%0d last=%0d",
                                 exp_r.wheel_v, exp_r.wheel_h,
                                 exp_r.button_out, exp_r.click_number, exp_r.last_of_run);
                        $write("  act kind=%0d xy=%0d,%0d step=%0d,%0d",
                               act.event_kind, act.ptr_x, act.ptr_y,
                               act.step_x, act.step_y);
                        $display(" wheel=%0d,%0d btn=%0d clk=%0d last=%0d",
                                 act.wheel_v, act.wheel_h,
                                 act.button_out, act.click_number, act.last_of_run);
                    end
                end
            end
        end
        if (rst_n && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("pointer_event_processor test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        mouse_event_t ev;
        if (rst_n && (!in_ch.valid || in_fire))
        begin
            if (pending_events.size() == 0 || $urandom_range(0, 99) < send_idle_pct)
                in_ch.valid <= 1'b0;
            else
            begin
                ev = pending_events.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.kind <= ev.kind;
                in_ch.move_x <= ev.move_x;
                in_ch.move_y <= ev.move_y;
                in_ch.scroll_v <= ev.scroll_v;
                in_ch.scroll_h <= ev.scroll_h;
                in_ch.button_index <= ev.button_index;
                in_ch.pos_x <= ev.pos_x;
                in_ch.pos_y <= ev.pos_y;
                in_ch.clicks_in <= ev.clicks_in;
                in_ch.time_ms <= ev.time_ms;
                events_sent <= events_sent + 1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic mouse_event_t random_event(logic [3:0] kind);
        mouse_event_t ev;
        ev.kind = kind;
        ev.move_x = 16'($urandom());
        ev.move_y = 16'($urandom());
        ev.scroll_v = 16'($urandom());
        ev.scroll_h = 16'($urandom());
        ev.button_index = 8'($urandom_range(0, NUM_BUTTONS - 1));
        ev.pos_x = 16'($urandom());
        ev.pos_y = 16'($urandom());
        ev.clicks_in = 8'($urandom());
        ev.time_ms = now_ms;
        return ev;
    endfunction

    function automatic void add_event(logic [3:0] kind, logic [7:0] btn, logic [31:0] t);
        mouse_event_t ev;
        now_ms = t;
        ev = random_event(kind);
        ev.button_index = btn;
        pending_events.push_back(ev);
    endfunction

    function automatic void add_move(int x, int y);
        mouse_event_t ev;
        ev = random_event(KIND_MOVE);
        ev.move_x = 16'(x);
        ev.move_y = 16'(y);
        pending_events.push_back(ev);
    endfunction

    // one burst of random traffic; returns the number of items queued
    function automatic int add_random_burst();
        mouse_event_t ev;
        int cat;
        int b;
        int lim;
        cat = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            now_ms = $urandom();
        else
            now_ms += $urandom_range(0, 60);
        if (cat < 30)
        begin
            ev = random_event(KIND_MOVE);
            lim = ($urandom_range(0, 2) == 0) ? 8 : 300;
            if ($urandom_range(0, 3) != 0)
            begin
                ev.move_x = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                ev.move_y = 16'(int'($urandom_range(0, 2 * lim)) - lim);
            end
            pending_events.push_back(ev);
            return 1;
        end
        if (cat < 62)
        begin
            b = $urandom_range(0, NUM_BUTTONS - 1);
            add_event(KIND_PRESS, b[7:0], now_ms);
            add_event(KIND_RELEASE, b[7:0], now_ms + $urandom_range(0, 450));
            return 2;
        end
        if (cat < 72)
        begin
            pending_events.push_back(random_event($urandom_range(0, 1) ? KIND_VSCROLL
                                                                       : KIND_HSCROLL));
            return 1;
        end
        if (cat < 78)
        begin
            pending_events.push_back(random_event(KIND_WARP));
            return 1;
        end
        if (cat < 86)
        begin
            pending_events.push_back(random_event(4'($urandom_range(6, 15))));
            return 1;
        end
        ev = random_event(4'($urandom_range(0, 15)));
        ev.button_index = 8'($urandom());
        pending_events.push_back(ev);
        return 1;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [15:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge clk);
        apply_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(logic [15:0] w, logic [15:0] h, logic [15:0] inv,
                             logic [15:0] gain, logic [15:0] knee, logic [15:0] deb,
                             logic [15:0] hold, logic [15:0] gap);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_INVERT, inv);
        write_reg(REG_GAIN, gain);
        write_reg(REG_KNEE, knee);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_HOLD, hold);
        write_reg(REG_GAP, gap);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_events.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        int queued;
        reset_pointer_state();
        errors = 0; idle_cycles = 0; events_sent = 0; results_seen = 0;
        clicks_seen = 0; dclicks_seen = 0; in_fire = 1'b0;
        hold_request = 1'b0; hold_left = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.move_x = '0; in_ch.move_y = '0;
        in_ch.scroll_v = '0; in_ch.scroll_h = '0; in_ch.button_index = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.clicks_in = '0; in_ch.time_ms = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        now_ms = 32'd1000;
        add_move(32767, 32767);
        add_move(-32768, -32768);
        add_move(0, 0);
        add_move(1, -1);
        add_move(3, -5);
        add_event(KIND_VSCROLL, 8'd0, 32'd1000);
        add_event(KIND_HSCROLL, 8'd0, 32'd1000);
        add_event(KIND_WARP, 8'd0, 32'd1000);
        pending_events[$].pos_x = 16'hFFFF;
        pending_events[$].pos_y = 16'hFFFF;
        add_event(KIND_WARP, 8'd0, 32'd1000);
        pending_events[$].pos_x = 16'h0000;
        pending_events[$].pos_y = 16'h0000;
        add_event(KIND_PRESS, 8'd0, 32'd1000);
        add_event(KIND_PRESS, 8'd0, 32'd1005);
        add_event(KIND_RELEASE, 8'd0, 32'd1100);
        add_event(KIND_PRESS, 8'd0, 32'd1200);
        add_event(KIND_RELEASE, 8'd0, 32'd1250);
        add_event(KIND_PRESS, 8'd1, 32'd2000);
        add_event(KIND_RELEASE, 8'd1, 32'd2500);
        add_event(KIND_RELEASE, 8'd1, 32'd2600);
        add_event(KIND_PRESS, 8'd8, 32'd2700);
        add_event(KIND_RELEASE, 8'd255, 32'd2800);
        add_event(KIND_PRESS, 8'd2, 32'hFFFF_FFF0);
        add_event(KIND_RELEASE, 8'd2, 32'h0000_0010);
        add_event(KIND_CLICK, 8'd3, 32'd20);
        add_event(KIND_DCLICK, 8'd4, 32'd20);
        add_event(4'd6, 8'd5, 32'd20);
        add_event(4'd13, 8'd6, 32'd20);

        for (int seg = 0; seg < 4; seg++)
        begin
            wait_drained();
            case (seg)
                0: write_all(16'd800, 16'd600, 16'd2, 16'd512, 16'd256, 16'd10, 16'd200, 16'd300);
                1: write_all(16'd0, 16'hFFFF, 16'd3, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
                2: write_all(16'hFFFF, 16'd1, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
                default: write_all(16'd1920, 16'd1080, 16'd0, 16'd384, 16'd1, 16'd5,
                                   16'd250, 16'd350);
            endcase
            send_idle_pct = (seg == 0) ? 14 : (seg == 1) ? 69 : 0;
            recv_idle_pct = (seg == 0) ? 69 : (seg == 1) ? 14 : 0;
            if (seg == 2)
                hold_request = 1'b1;
            queued = 0;
            while (queued < SEG_ITEMS)
                queued += add_random_burst();
        end

        wait_drained();
        $display("Sent %0d mouse events, checked %0d results (%0d clicks, %0d double clicks)",
                 events_sent, results_seen, clicks_seen, dclicks_seen);
        $display("Covered four register settings including size, gain and knee extremes");
        if (errors == 0)
            $display("pointer_event_processor test passed");
        else
        begin
            $display("%0d mismatches", errors);
            $display("pointer_event_processor test failed");
        end
        $finish;
    end
endmodule
